[design/bffa_pkg.sv]
// shared constants, request codes, sequencer states and the structs
// that pass between the word unit and the sequencer of the allocator
// no dependencies
package bffa_pkg;

	localparam int ADDR_W         = 32;
	localparam int BYTES_W        = 24;
	localparam int BLOCK_SHIFT    = 12;
	localparam int BLOCK_BYTES    = 1 << BLOCK_SHIFT;
	localparam int WORD_BITS      = 32;
	localparam int WORD_SHIFT     = 5;
	localparam int NEED_W         = BYTES_W - BLOCK_SHIFT + 1;
	localparam int DIFF_W         = ADDR_W + 1;
	localparam int Q_W            = DIFF_W - BLOCK_SHIFT;
	localparam int DEF_NUM_BLOCKS = 1024;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_RESERVE = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_RANGE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_MARK_RD,
		S_MARK_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                  hit;
		logic [WORD_SHIFT-1:0] hit_bit;
		logic [NEED_W-1:0]     carry;
	} scan_res_t;

	typedef struct packed {
		logic                  set_val;
		logic                  lo_first;
		logic                  hi_last;
		logic [WORD_SHIFT-1:0] lo_bit;
		logic [WORD_SHIFT-1:0] hi_bit;
	} mark_ctl_t;

endpackage

[design/bffa_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module bffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/bffa_word_unit.sv]
// shared word unit: first-fit run search over one bitmap word with the
// free run carried in from lower words, and masked set/clear of a word
// depends on bffa_pkg
module bffa_word_unit import bffa_pkg::*; #(
	parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
	input  logic [WORD_BITS-1:0] rdata,
	input  logic                 last_word,
	input  logic [NEED_W-1:0]    need,
	input  logic [NEED_W-1:0]    carry_in,
	input  mark_ctl_t            mark,
	output scan_res_t            scan,
	output logic [WORD_BITS-1:0] wdata
);

	localparam int TAIL = NUM_BLOCKS % WORD_BITS;
	localparam logic [WORD_BITS-1:0] TAIL_INV = (TAIL == 0) ? '0 :
		~((WORD_BITS'(1) << TAIL) - WORD_BITS'(1));

	logic [WORD_BITS-1:0] eff;
	logic [WORD_BITS-1:0] hit_vec;
	logic [NEED_W:0]      csum;
	logic [WORD_SHIFT:0]  top_free;
	logic [WORD_BITS-1:0] lo_m;
	logic [WORD_BITS-1:0] hi_m;
	logic [WORD_BITS-1:0] m;

	// blocks past the end of the heap look allocated
	assign eff = rdata | (last_word ? TAIL_INV : '0);

	always_comb begin
		logic [NEED_W-1:0]    span;
		logic [NEED_W-1:0]    low;
		logic [WORD_BITS-1:0] win;
		logic                 seg_ok;
		logic                 carry_ok;
		for (int i = 0; i < WORD_BITS; i++) begin
			span = NEED_W'(i + 1);
			low = (need <= span) ? (span - need) : '0;
			// window of the run ending at bit i, limited to this word
			win = ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - i)) &
				~((WORD_BITS'(1) << low[WORD_SHIFT-1:0]) - WORD_BITS'(1));
			seg_ok = (eff & win) == '0;
			carry_ok = (need <= span) ||
				(({1'b0, carry_in} + (NEED_W + 1)'(i + 1)) >= {1'b0, need});
			hit_vec[i] = seg_ok && carry_ok;
		end
	end

	always_comb begin
		scan.hit = |hit_vec;
		scan.hit_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				scan.hit_bit = WORD_SHIFT'(i);
			end
		end
	end

	// free run at the top of the word, saturated at the request size
	assign csum = {1'b0, carry_in} + (NEED_W + 1)'(WORD_BITS);

	always_comb begin
		top_free = (WORD_SHIFT + 1)'(WORD_BITS);
		for (int b = 0; b < WORD_BITS; b++) begin
			if (eff[b]) begin
				top_free = (WORD_SHIFT + 1)'(WORD_BITS - 1 - b);
			end
		end
		if (eff == '0) begin
			scan.carry = (csum > {1'b0, need}) ? need : csum[NEED_W-1:0];
		end else begin
			scan.carry = NEED_W'(top_free);
		end
	end

	assign lo_m = mark.lo_first ? ({WORD_BITS{1'b1}} << mark.lo_bit) : '1;
	assign hi_m = mark.hi_last ?
		({WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - mark.hi_bit)) : '1;
	assign m = lo_m & hi_m;
	assign wdata = mark.set_val ? (rdata | m) : (rdata & ~m);

endmodule

[design/bitmap_first_fit_block_allocator_unit.sv]
// Bitmap first-fit block allocator: one bit per 4 KiB heap block, kept in a
// ram of 32-bit words and read one word at a time. After reset the map is
// cleared word by word before the first request is taken. Requests are
// handled one at a time. Each bitmap word read is a registered ram read,
// then an evaluate or write-back step. An allocate scans words from the
// start of the map until a free run of the request size is found, then
// sets the bits of that run; a free clears and a reserve sets the bits
// of its range. A finished result waits in the output register while the
// next request is accepted.
// depends on bffa_pkg, bffa_ram, bffa_word_unit
module bitmap_first_fit_block_allocator_unit import bffa_pkg::*; #(
	parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ADDR_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [ADDR_W-1:0]  address,
	input  logic [BYTES_W-1:0] byte_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ADDR_W-1:0]  alloc_address,
	output logic               status
);

	localparam int DEPTH = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = AW + WORD_SHIFT + 1;
	localparam logic [AW-1:0] LAST_W = AW'(DEPTH - 1);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] heap_base_q;
	req_t              type_q;
	logic              addr_nz_q;
	logic [NEED_W-1:0] need_q;
	logic [DIFF_W-1:0] diff_q;
	logic [Q_W-1:0]    q_q;
	logic              neg_q;
	logic [IW-1:0]     lo_q;
	logic [IW-1:0]     last_q;
	logic              set_q;
	logic [AW-1:0]     w_q;
	logic [NEED_W-1:0] carry_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] alloc_address_q;
	logic              status_q;

	logic                 in_xfer;
	logic                 out_xfer;
	logic                 out_load;
	logic                 ram_we;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] mark_wdata;
	logic [NEED_W-1:0]    need_in;
	logic                 need_zero;
	logic                 need_big;
	logic [DIFF_W-1:0]    mag;
	logic [31:0]          lo_r;
	logic [31:0]          hi_r;
	logic                 range_empty;
	logic [IW-1:0]        hit_last;
	logic [IW-1:0]        hit_lo;
	logic                 at_last_mark;
	scan_res_t            scan;
	mark_ctl_t            mark;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign alloc_address = alloc_address_q;
	assign status    = status_q;

	// round up to whole blocks
	assign need_in = NEED_W'(byte_count >> BLOCK_SHIFT) +
		NEED_W'(byte_count[BLOCK_SHIFT-1:0] != '0);
	assign need_zero = (need_q == '0);
	assign need_big  = (32'(need_q) > 32'(NUM_BLOCKS));

	// start block truncates toward zero
	assign mag = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;

	always_comb begin
		range_empty = 1'b0;
		lo_r = '0;
		hi_r = '0;
		if (neg_q) begin
			if (32'(q_q) >= 32'(need_q)) begin
				range_empty = 1'b1;
			end else begin
				hi_r = 32'(need_q) - 32'(q_q);
			end
		end else begin
			if (32'(q_q) >= 32'(NUM_BLOCKS)) begin
				range_empty = 1'b1;
			end else begin
				lo_r = 32'(q_q);
				hi_r = 32'(q_q) + 32'(need_q);
			end
		end
		if (hi_r > 32'(NUM_BLOCKS)) begin
			hi_r = 32'(NUM_BLOCKS);
		end
		if (lo_r >= hi_r) begin
			range_empty = 1'b1;
		end
	end

	assign hit_last = {1'b0, w_q, scan.hit_bit};
	assign hit_lo   = hit_last - IW'(need_q) + IW'(1);
	assign at_last_mark = (w_q == last_q[WORD_SHIFT +: AW]);

	assign mark.set_val  = set_q;
	assign mark.lo_first = (w_q == lo_q[WORD_SHIFT +: AW]);
	assign mark.hi_last  = at_last_mark;
	assign mark.lo_bit   = lo_q[WORD_SHIFT-1:0];
	assign mark.hi_bit   = last_q[WORD_SHIFT-1:0];

	bffa_word_unit #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_word (
		.rdata    (rdata),
		.last_word(w_q == LAST_W),
		.need     (need_q),
		.carry_in (carry_q),
		.mark     (mark),
		.scan     (scan),
		.wdata    (mark_wdata)
	);

	bffa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_q),
		.wdata(ram_wdata),
		.raddr(w_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_wdata = mark_wdata;
		out_load  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (w_q == LAST_W) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				unique case (type_q)
					REQ_ALLOC: begin
						if (need_zero || need_big) begin
							state_d = S_DONE;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					REQ_FREE: begin
						if (!addr_nz_q || need_zero) begin
							state_d = S_DONE;
						end else begin
							state_d = S_RANGE;
						end
					end
					REQ_RESERVE: state_d = S_RANGE;
					REQ_NONE:    state_d = S_DONE;
					default:     state_d = S_DONE;
				endcase
			end
			S_RANGE: begin
				state_d = range_empty ? S_DONE : S_MARK_RD;
			end
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				priority if (scan.hit) begin
					state_d = S_MARK_RD;
				end else if (w_q == LAST_W) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_MARK_RD: state_d = S_MARK_WR;
			S_MARK_WR: begin
				ram_we = 1'b1;
				state_d = at_last_mark ? S_DONE : S_MARK_RD;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			w_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_base_q <= cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: w_q <= (w_q == LAST_W) ? '0 : w_q + AW'(1);
				S_PREP:  w_q <= '0;
				S_RANGE: w_q <= lo_r[WORD_SHIFT +: AW];
				S_SCAN_EV: begin
					if (scan.hit) begin
						w_q <= hit_lo[WORD_SHIFT +: AW];
					end else if (w_q != LAST_W) begin
						w_q <= w_q + AW'(1);
					end
				end
				S_MARK_WR: begin
					if (!at_last_mark) begin
						w_q <= w_q + AW'(1);
					end
				end
				default: w_q <= w_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			type_q    <= req_t'(req_type);
			addr_nz_q <= (address != '0);
			need_q    <= need_in;
			diff_q    <= {1'b0, address} - {1'b0, heap_base_q};
		end
		unique case (state_q)
			S_PREP: begin
				q_q          <= mag[DIFF_W-1:BLOCK_SHIFT];
				neg_q        <= diff_q[DIFF_W-1];
				carry_q      <= '0;
				set_q        <= (type_q != REQ_FREE);
				res_addr_q   <= (type_q == REQ_ALLOC && need_zero) ? heap_base_q : '0;
				res_status_q <= (type_q == REQ_ALLOC) && !need_zero && need_big;
			end
			S_RANGE: begin
				lo_q   <= IW'(lo_r);
				last_q <= IW'(hi_r) - IW'(1);
			end
			S_SCAN_EV: begin
				if (scan.hit) begin
					lo_q   <= hit_lo;
					last_q <= hit_last;
				end else begin
					carry_q <= scan.carry;
					if (w_q == LAST_W) begin
						res_status_q <= 1'b1;
					end
				end
			end
			S_MARK_WR: begin
				if (at_last_mark && type_q == REQ_ALLOC) begin
					res_addr_q <= heap_base_q + (ADDR_W'(lo_q) << BLOCK_SHIFT);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			alloc_address_q <= res_addr_q;
			status_q        <= res_status_q;
		end
	end

	// map writes only come from the clearing pass or the mark write-back
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_MARK_WR))
		else $error("bitmap write outside clear or mark");

	// marking stays inside the words of the range
	a_mark_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK_RD || state_q == S_MARK_WR) |->
		(w_q >= lo_q[WORD_SHIFT +: AW] && w_q <= last_q[WORD_SHIFT +: AW]
		&& lo_q <= last_q))
		else $error("mark word outside range");

	// a carried free run never reaches the request size without a hit
	a_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_EV) |-> (carry_q < need_q))
		else $error("carried run reached request size");

	// a new result appears only from the done state
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without finished request");

endmodule
